// ----- design/utt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package utt_pkg;

  // decoder state codes that carry meaning outside the transition table
  localparam logic [3:0] DFA_ACCEPT     = 4'd0;
  localparam logic [3:0] DFA_REJECT     = 4'd1;
  localparam logic [3:0] DFA_LAST_STATE = 4'd8;

  // byte classes named where the transition table tests them
  localparam logic [3:0] CLS_CONT_LO  = 4'd1;  // 0x80..0x8f
  localparam logic [3:0] CLS_CONT_HI  = 4'd7;  // 0xa0..0xbf
  localparam logic [3:0] CLS_CONT_MID = 4'd9;  // 0x90..0x9f

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hfffd;
  localparam logic [20:0] CP_SURR_FIRST    = 21'h00d800;
  localparam logic [20:0] CP_SURR_LAST     = 21'h00dfff;
  localparam logic [20:0] CP_BMP_LAST      = 21'h00ffff;

  localparam int QUEUE_DEPTH  = 4;
  localparam int REPLAY_DEPTH = 3;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic load;          // take a new byte into the queue
    logic step;          // decode the byte at the queue head
    logic res_to_out;    // decoded result straight into the output register
    logic res_to_pend;   // decoded result into the holding register
    logic pend_to_out;   // holding register into the output register
    logic fin_trunc;     // truncated string: replacement into the holding register
    logic end_only_out;  // end-only result into the output register
    logic mark_end;      // result written this cycle closes the string
    logic clear;         // return decoder state to reset values
  } utt_cmd_t;

  typedef struct packed {
    logic last;        // current byte carries the end mark
    logic halted;      // null seen, bytes ignored until the end mark
    logic q_empty;
    logic emits;       // head byte produces a result
    logic drains;      // head byte leaves the queue empty
    logic trunc;       // sequence still open
    logic pend_valid;
    logic out_free;    // output register can take a result this cycle
  } utt_status_t;

  function automatic logic [3:0] byte_class(input octet_t b);
    logic [3:0] cls;
    unique case (b) inside
      [8'h00:8'h7f]: cls = 4'd0;
      [8'h80:8'h8f]: cls = CLS_CONT_LO;
      [8'h90:8'h9f]: cls = CLS_CONT_MID;
      [8'ha0:8'hbf]: cls = CLS_CONT_HI;
      [8'hc0:8'hc1]: cls = 4'd8;
      [8'hc2:8'hdf]: cls = 4'd2;
      8'he0:         cls = 4'd10;
      [8'he1:8'hec]: cls = 4'd3;
      8'hed:         cls = 4'd4;
      [8'hee:8'hef]: cls = 4'd3;
      8'hf0:         cls = 4'd11;
      [8'hf1:8'hf3]: cls = 4'd6;
      8'hf4:         cls = 4'd5;
      default:       cls = 4'd8;
    endcase
    return cls;
  endfunction

  function automatic logic [3:0] dfa_next(input logic [3:0] cur, input logic [3:0] cls);
    logic lo;
    logic mid;
    logic hi;
    logic [3:0] nxt;
    lo  = (cls == CLS_CONT_LO);
    mid = (cls == CLS_CONT_MID);
    hi  = (cls == CLS_CONT_HI);
    nxt = DFA_REJECT;
    unique case (cur)
      4'd0: begin
        unique case (cls)
          4'd0:    nxt = DFA_ACCEPT;
          4'd2:    nxt = 4'd2;
          4'd3:    nxt = 4'd3;
          4'd4:    nxt = 4'd5;
          4'd5:    nxt = 4'd8;
          4'd6:    nxt = 4'd7;
          4'd10:   nxt = 4'd4;
          4'd11:   nxt = 4'd6;
          default: nxt = DFA_REJECT;
        endcase
      end
      4'd2: if (lo || mid || hi) nxt = DFA_ACCEPT;
      4'd3: if (lo || mid || hi) nxt = 4'd2;
      4'd4: if (hi) nxt = 4'd2;
      4'd5: if (lo || mid) nxt = 4'd2;
      4'd6: if (mid || hi) nxt = 4'd3;
      4'd7: if (lo || mid || hi) nxt = 4'd3;
      4'd8: if (lo) nxt = 4'd3;
      default: nxt = DFA_REJECT;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- design/utt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- design/utt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface utt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        was_replaced;
  logic        end_of_string;

  modport source (output valid, output code_unit, output unit_valid, output was_replaced,
                  output end_of_string, input ready);
  modport sink (input valid, input code_unit, input unit_valid, input was_replaced,
                input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- design/utt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utt_datapath
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire utt_cmd_t    cmd,
  output utt_status_t      st,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output logic [15:0]      code_unit,
  output logic             unit_valid,
  output logic             was_replaced,
  output logic             end_of_string,
  output logic             out_valid,
  input  wire logic        out_ready
);

  octet_t      queue [QUEUE_DEPTH];
  logic [2:0]  q_count;
  octet_t      replay [REPLAY_DEPTH];
  logic [1:0]  replay_count;
  logic [3:0]  dfa_state;
  logic [20:0] accum;
  logic        halted;
  logic        last;
  logic [15:0] pend_unit;
  logic        pend_repl;
  logic        pend_valid;

  octet_t      head;
  logic [3:0]  cls;
  logic        prev_open;
  logic [7:0]  lead_mask;
  logic [20:0] accum_next;
  logic [3:0]  next_state;
  logic        is_accept;
  logic        is_reject;
  logic        is_null;
  logic        replay_now;
  logic        in_ucs2;
  logic [15:0] res_unit;
  logic        res_repl;
  logic        out_write;

  assign head       = queue[0];
  assign cls        = byte_class(head);
  assign prev_open  = (dfa_state != DFA_ACCEPT);
  assign lead_mask  = 8'hff >> cls;
  assign accum_next = prev_open ? {accum[14:0], head[5:0]} : {13'd0, lead_mask & head};
  assign next_state = (dfa_state <= DFA_LAST_STATE) ? dfa_next(dfa_state, cls) : DFA_REJECT;
  assign is_accept  = (next_state == DFA_ACCEPT);
  assign is_reject  = (next_state == DFA_REJECT);
  assign is_null    = is_accept && (accum_next == 21'd0);
  assign replay_now = is_reject && prev_open;

  // surrogates and anything past the basic plane become the replacement character
  assign in_ucs2 = (accum_next <= CP_BMP_LAST) &&
                   !((accum_next >= CP_SURR_FIRST) && (accum_next <= CP_SURR_LAST));

  always_comb begin
    if (is_reject || !in_ucs2) begin
      res_unit = REPLACEMENT_CHAR;
      res_repl = 1'b1;
    end else begin
      res_unit = accum_next[15:0];
      res_repl = 1'b0;
    end
  end

  assign out_write = cmd.res_to_out || cmd.pend_to_out || cmd.end_only_out;

  always_comb begin
    st.last       = last;
    st.halted     = halted;
    st.q_empty    = (q_count == 3'd0);
    st.emits      = (is_accept && !is_null) || is_reject;
    st.drains     = is_null || ((q_count == 3'd1) && !replay_now);
    st.trunc      = !halted && prev_open;
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || out_ready;
  end

  // byte queue; a rejected open sequence is refilled with its held bytes and the rejecting byte
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 3'd0;
    end else if (cmd.load) begin
      queue[0] <= in_byte;
      q_count  <= 3'd1;
    end else if (cmd.step) begin
      if (is_null) begin
        q_count <= 3'd0;
      end else if (replay_now) begin
        for (int i = 0; i < REPLAY_DEPTH; i++) begin
          queue[i] <= (2'(i) < replay_count) ? replay[i] : head;
        end
        queue[QUEUE_DEPTH-1] <= head;
        q_count <= {1'b0, replay_count} + 3'd1;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          queue[i] <= queue[i+1];
        end
        q_count <= q_count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (cmd.load) begin
      last <= end_of_input;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dfa_state    <= DFA_ACCEPT;
      accum        <= 21'd0;
      replay_count <= 2'd0;
      halted       <= 1'b0;
    end else if (cmd.fin_trunc) begin
      dfa_state <= DFA_ACCEPT;
    end else if (cmd.step) begin
      accum <= accum_next;
      if (is_null) begin
        halted <= 1'b1;
      end
      if (is_accept || is_reject) begin
        dfa_state    <= DFA_ACCEPT;
        replay_count <= 2'd0;
      end else begin
        dfa_state <= next_state;
        if (!prev_open) begin
          replay_count <= 2'd0;
        end else if (replay_count != 2'(REPLAY_DEPTH)) begin
          replay[replay_count] <= head;
          replay_count         <= replay_count + 2'd1;
        end
      end
    end
  end

  // holding register, used on the final byte so the closing result can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.fin_trunc) begin
      pend_unit  <= REPLACEMENT_CHAR;
      pend_repl  <= 1'b1;
      pend_valid <= 1'b1;
    end else if (cmd.res_to_pend) begin
      pend_unit  <= res_unit;
      pend_repl  <= res_repl;
      pend_valid <= 1'b1;
    end else if (cmd.pend_to_out || cmd.clear) begin
      pend_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_to_out) begin
      code_unit     <= res_unit;
      unit_valid    <= 1'b1;
      was_replaced  <= res_repl;
      end_of_string <= cmd.mark_end;
    end else if (cmd.pend_to_out) begin
      code_unit     <= pend_unit;
      unit_valid    <= 1'b1;
      was_replaced  <= pend_repl;
      end_of_string <= cmd.mark_end;
    end else if (cmd.end_only_out) begin
      code_unit     <= 16'd0;
      unit_valid    <= 1'b0;
      was_replaced  <= 1'b0;
      end_of_string <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/utt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utt_ctrl
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire utt_status_t st,
  output utt_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_step;

  // a result on the final byte goes to the holding register, which pushes its
  // previous occupant to the output register
  assign can_step = !st.emits ||
                    (st.last ? (!st.pend_valid || st.out_free) : st.out_free);

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (st.halted || st.q_empty) begin
          state_next = st.last ? S_FIN : S_IDLE;
        end else if (can_step) begin
          cmd.step = 1'b1;
          if (st.emits) begin
            if (st.last) begin
              cmd.res_to_pend = 1'b1;
              cmd.pend_to_out = st.pend_valid;
            end else begin
              cmd.res_to_out = 1'b1;
            end
          end
          if (st.drains) begin
            state_next = st.last ? S_FIN : S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (st.trunc) begin
          if (!st.pend_valid || st.out_free) begin
            cmd.fin_trunc   = 1'b1;
            cmd.pend_to_out = st.pend_valid;
          end
        end else if (st.out_free) begin
          cmd.mark_end     = 1'b1;
          cmd.clear        = 1'b1;
          cmd.pend_to_out  = st.pend_valid;
          cmd.end_only_out = !st.pend_valid;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8_to_ucs2_transcoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// utf-8 to ucs-2 transcoder
// utf8 channel: one raw byte per transaction, with end_of_input on the last byte
// of a string. ucs2 channel: one 16-bit code unit per transaction; unit_valid is
// low only on an end-only transaction, was_replaced flags a substituted 0xfffd,
// end_of_string marks the final transaction of the string.
// timing: a byte is taken in the idle state and decoded in the step state; the
// utf8 side is ready again only after the queue has drained. a sequence rejected
// after its lead byte is decoded again, each held byte plus the rejecting byte
// (at most three bytes). the final byte of a string adds a closing step in the
// finish state, which first writes a replacement when the string ends mid-
// sequence. the decoder decodes one byte per cycle while its results can be written.
// results appear in the output register in the cycle after the decode cycle that
// made them; on the final byte each result waits in the holding register so that
// the last one can carry end_of_string.
// reset: synchronous, clears the decoder to the accept state and empties the
// output register. when the receiver stalls the output register holds its
// transaction and decoding waits, so the utf8 side stops being ready.

module utf8_to_ucs2_transcoder_top
  import utt_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  utt_in_if.sink     utf8,
  utt_out_if.source  ucs2
);

  utt_cmd_t    cmd;
  utt_status_t st;
  logic        in_ready;

  // sequencer: owns the handshake and routing of each result
  utt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (utf8.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign utf8.ready = in_ready;

  // byte queue, table-driven decoder, holding and output registers
  utt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_byte       (utf8.in_byte),
    .end_of_input  (utf8.end_of_input),
    .code_unit     (ucs2.code_unit),
    .unit_valid    (ucs2.unit_valid),
    .was_replaced  (ucs2.was_replaced),
    .end_of_string (ucs2.end_of_string),
    .out_valid     (ucs2.valid),
    .out_ready     (ucs2.ready)
  );

endmodule

`default_nettype wire
